### rtl/i2cbs_pkg.sv
// shared types, command codes and pin step table for the i2c master bit sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package i2cbs_pkg;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	localparam int STEP_W = 5;

	// index of the final pin step of each command
	localparam logic [STEP_W-1:0] LAST_IDX_START = 5'd2;
	localparam logic [STEP_W-1:0] LAST_IDX_STOP  = 5'd2;
	localparam logic [STEP_W-1:0] LAST_IDX_WRITE = 5'd18;
	localparam logic [STEP_W-1:0] LAST_IDX_READ  = 5'd20;

	// classified command as it waits in the queue
	typedef struct packed {
		mode_t             mode;
		logic [7:0]        wr_byte;
		logic              master_ack;
		logic [7:0]        rd_byte;
		logic              slave_acked;
		logic [STEP_W-1:0] last_idx;
	} cmd_desc_t;

	typedef struct packed {
		logic sda_low;
		logic scl_low;
	} pins_t;

	// pin levels of one step of a command
	function automatic pins_t step_pins(input cmd_desc_t desc, input logic [STEP_W-1:0] idx);
		pins_t p;
		p = '{sda_low: 1'b0, scl_low: 1'b0};
		case (desc.mode)
			MODE_START: begin
				p.sda_low = (idx != 5'd0);
				p.scl_low = (idx == 5'd2);
			end
			MODE_STOP: begin
				p.sda_low = (idx != 5'd2);
				p.scl_low = (idx == 5'd0);
			end
			MODE_WRITE: begin
				if (idx < 5'd16) begin
					// bit 7 - idx/2, msb first, scl low on the even half
					p.sda_low = ~desc.wr_byte[~idx[3:1]];
					p.scl_low = ~idx[0];
				end else begin
					p.sda_low = 1'b0;
					p.scl_low = (idx != 5'd17);
				end
			end
			MODE_READ: begin
				if (idx == 5'd0) begin
					p.scl_low = 1'b1;
				end else if (idx < 5'd17) begin
					p.scl_low = ~idx[0];
				end else begin
					// ack slot, then release sda with scl low
					p.sda_low = desc.master_ack && (idx != 5'd20);
					p.scl_low = (idx != 5'd18);
				end
			end
			default: begin
				p = '{sda_low: 1'b0, scl_low: 1'b0};
			end
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/i2cbs_front.sv
// front end: takes command transactions and classifies them into queue descriptors
// depends on i2cbs_pkg
`default_nettype none

module i2cbs_front
	import i2cbs_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] write_byte,
	input  wire logic       master_ack,
	input  wire logic [8:0] bus_sda_samples,
	input  wire logic       q_full,
	output logic            q_push,
	output cmd_desc_t       q_desc
);

	mode_t cmd_mode;

	assign cmd_mode = mode_t'(mode);
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_desc             = '0;
		q_desc.mode        = cmd_mode;
		q_desc.wr_byte     = write_byte;
		q_desc.master_ack  = master_ack;
		case (cmd_mode)
			MODE_START: q_desc.last_idx = LAST_IDX_START;
			MODE_STOP:  q_desc.last_idx = LAST_IDX_STOP;
			MODE_WRITE: begin
				q_desc.last_idx    = LAST_IDX_WRITE;
				q_desc.slave_acked = ~bus_sda_samples[8];
			end
			MODE_READ: begin
				q_desc.last_idx = LAST_IDX_READ;
				q_desc.rd_byte  = bus_sda_samples[7:0];
			end
			default: q_desc.last_idx = LAST_IDX_START;
		endcase
	end

endmodule

`default_nettype wire

### rtl/i2cbs_queue.sv
// short command queue between the front and back ends
// depends on i2cbs_pkg for the descriptor type
`default_nettype none

module i2cbs_queue
	import i2cbs_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_desc_t push_desc,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output cmd_desc_t      head_desc
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_desc_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> count_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/i2cbs_back.sv
// back end: walks the head command one pin step per cycle into the output register, unless out_stall holds it
// depends on i2cbs_pkg for the descriptor type and the step table
`default_nettype none

module i2cbs_back
	import i2cbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire cmd_desc_t head_desc,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic           sda_drive_low,
	output logic           scl_drive_low,
	output logic           last_step,
	output logic [7:0]     read_byte,
	output logic           slave_acked
);

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;
	logic              load;
	logic              is_last;
	pins_t             pins;

	logic       sda_q;
	logic       scl_q;
	logic       last_q;
	logic [7:0] rd_byte_q;
	logic       ack_q;

	assign out_free = !out_valid_q || !out_stall;
	assign load     = head_valid && out_free;
	assign is_last  = (step_q == head_desc.last_idx);
	assign pop      = load && is_last;
	assign pins     = step_pins(head_desc, step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				step_q <= is_last ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sda_q     <= pins.sda_low;
			scl_q     <= pins.scl_low;
			last_q    <= is_last;
			rd_byte_q <= is_last ? head_desc.rd_byte : 8'd0;
			ack_q     <= is_last && head_desc.slave_acked;
		end
	end

	assign out_valid     = out_valid_q;
	assign sda_drive_low = sda_q;
	assign scl_drive_low = scl_q;
	assign last_step     = last_q;
	assign read_byte     = rd_byte_q;
	assign slave_acked   = ack_q;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n) (step_q != '0) |-> head_valid)
		else $error("step counter running with no command at the head");
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> step_q <= head_desc.last_idx)
		else $error("step counter past the last step of the command");
`endif

endmodule

`default_nettype wire

### rtl/i2c_master_bit_sequencer_core.sv
// top level of the open-drain i2c master pin sequencer
// depends on i2cbs_pkg, i2cbs_front, i2cbs_queue and i2cbs_back
//
// channel  direction  handshake            payload
// input    in         in_valid / in_stall   mode, write_byte, master_ack, bus_sda_samples
// output   out        out_valid / out_stall sda_drive_low, scl_drive_low, last_step,
//                                           read_byte, slave_acked
//
// one pin step leaves per cycle unless out_stall holds it: start and stop have 3 steps, write 19, read 21,
// set by the step counter in the back end walking the head command
// commands are accepted whenever the queue has room, so the next one is
// taken while the current one is still being stepped out
// reset clears the queue pointers, the step counter and the output valid
// out_stall holds the output register and the step counter; the queue keeps filling
`default_nettype none

module i2c_master_bit_sequencer_core
	import i2cbs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2 // commands buffered between front and back, 2..32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] write_byte,
	input  wire logic       master_ack,
	input  wire logic [8:0] bus_sda_samples,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            sda_drive_low,
	output logic            scl_drive_low,
	output logic            last_step,
	output logic [7:0]      read_byte,
	output logic            slave_acked
);

	// front to queue
	logic      q_full;
	logic      q_push;
	cmd_desc_t q_desc;

	// queue to back
	logic      q_pop;
	logic      head_valid;
	cmd_desc_t head_desc;

	// decode: sample bits are resolved into read byte and ack flag here
	i2cbs_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.write_byte      (write_byte),
		.master_ack      (master_ack),
		.bus_sda_samples (bus_sda_samples),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_desc          (q_desc)
	);

	// decouples command acceptance from pin stepping
	i2cbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_desc),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// steps the head command; pops it when its last step is loaded
	i2cbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_desc     (head_desc),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sda_drive_low (sda_drive_low),
		.scl_drive_low (scl_drive_low),
		.last_step     (last_step),
		.read_byte     (read_byte),
		.slave_acked   (slave_acked)
	);

endmodule

`default_nettype wire
